// ===== design/assert_macros.svh =====
// Assertion helpers for the echo RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define NCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define NCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nce_pkg.sv =====
package nce_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int STORE_BITS  = SAMPLE_BITS + 8;
    localparam int MAX_DELAY   = 32768;
    localparam int ADDR_BITS   = $clog2(MAX_DELAY);
    localparam int CFG_BITS    = 16;
    localparam int FILL_BITS   = 16;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [1:0] REG_FEEDBACK_GAIN = 2'd0;
    localparam logic [1:0] REG_NORM_GAIN     = 2'd1;
    localparam logic [1:0] REG_ECHO_SPACING  = 2'd2;

    localparam logic [CFG_BITS-1:0] FEEDBACK_GAIN_RESET = 16'd16384;
    localparam logic [CFG_BITS-1:0] NORM_GAIN_RESET     = 16'd16384;
    localparam logic [CFG_BITS-1:0] ECHO_SPACING_RESET  = 16'd4800;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [STORE_BITS-1:0]  store_word_t;
    typedef logic [ADDR_BITS-1:0]          store_addr_t;

endpackage

// ===== design/nce_in_if.sv =====
interface nce_in_if import nce_pkg::*;;

    logic    valid;
    logic    ready;
    sample_t sample_in;
    logic    clip_start;

    modport source (output valid, output sample_in, output clip_start, input ready);
    modport sink (input valid, input sample_in, input clip_start, output ready);

endinterface

// ===== design/nce_out_if.sv =====
interface nce_out_if import nce_pkg::*;;

    logic    valid;
    logic    ready;
    sample_t sample_out;
    logic    clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink (input valid, input sample_out, input clipped, output ready);

endinterface

// ===== design/normalized_echo_comb.sv =====
// Recursive echo with output normalization. The delayed value is read from the echo memory
// as each sample is accepted; then a sequencer runs one shared 17x24 multiplier twice
// (feedback, then normalization) with a store and a rounding step in between. The result
// sits in an output register, so a new sample is taken as soon as the sequencer is free,
// even while the previous result waits. The echo memory is not cleared after reset; a fill
// count, restarted by clip_start, makes delayed reads return zero until enough samples have
// been written.
`include "assert_macros.svh"

module normalized_echo_comb import nce_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    nce_in_if.sink                   audio,
    nce_out_if.source                echo,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam int PROD_BITS = 17 + STORE_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;

    logic [2:0]          state_reg, state_next;
    logic [CFG_BITS-1:0] gain_reg, norm_reg, spacing_reg;
    store_addr_t         wp_reg;
    logic [FILL_BITS-1:0] fill_reg;

    sample_t             x_reg;
    logic                gate_reg;
    store_word_t         rd_data_reg;
    store_word_t         w_reg;
    logic                hit_reg;
    logic signed [PROD_BITS-1:0] prod_reg;

    logic                out_valid_reg;
    sample_t             out_sample_reg;
    logic                out_clipped_reg;

    store_word_t         echo_mem [MAX_DELAY];

    logic                cfg_write;
    logic                accept;
    logic                out_load;
    logic [FILL_BITS-1:0] delay;
    logic [FILL_BITS-1:0] fill_eff;
    store_addr_t         rd_addr;

    logic signed [16:0]           mul_a;
    store_word_t                  mul_b;
    logic signed [SUM_BITS-1:0]   sum_fb;
    logic signed [SUM_BITS-1:0]   shift_fb;
    logic signed [STORE_BITS+2:0] w_full;
    store_word_t                  w_sat;
    logic                         w_hit;
    logic signed [SUM_BITS-1:0]   sum_out;
    logic signed [SUM_BITS-1:0]   shift_out;
    sample_t                      y_sat;
    logic                         y_hit;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_FEEDBACK_GAIN: prdata = {{(APB_DATA_BITS-CFG_BITS){1'b0}}, gain_reg};
            REG_NORM_GAIN:     prdata = {{(APB_DATA_BITS-CFG_BITS){1'b0}}, norm_reg};
            REG_ECHO_SPACING:  prdata = {{(APB_DATA_BITS-CFG_BITS){1'b0}}, spacing_reg};
            default:           prdata = '0;
        endcase
    end

    assign audio.ready = (state_reg == S_IDLE);
    assign accept      = audio.valid && audio.ready;

    assign echo.valid      = out_valid_reg;
    assign echo.sample_out = out_sample_reg;
    assign echo.clipped    = out_clipped_reg;

    always_comb
    begin
        if (spacing_reg == '0)
        begin
            delay = FILL_BITS'(1);
        end
        else if (spacing_reg > FILL_BITS'(MAX_DELAY))
        begin
            delay = FILL_BITS'(MAX_DELAY);
        end
        else
        begin
            delay = spacing_reg;
        end
    end

    assign fill_eff = audio.clip_start ? '0 : fill_reg;
    assign rd_addr  = wp_reg - delay[ADDR_BITS-1:0];

    // Shared multiplier: feedback gain times delayed value, then stored value times norm.
    assign mul_a = (state_reg == S_MUL1) ? {gain_reg[CFG_BITS-1], gain_reg} : {1'b0, norm_reg};
    assign mul_b = (state_reg == S_MUL1) ? (gate_reg ? rd_data_reg : '0) : w_reg;

    always_comb
    begin
        sum_fb   = {prod_reg[PROD_BITS-1], prod_reg} + SUM_BITS'(16384);
        shift_fb = sum_fb >>> 15;
        w_full   = (STORE_BITS+3)'(x_reg) + shift_fb[STORE_BITS+2:0];
        w_hit    = 1'b0;
        if (w_full > (STORE_BITS+3)'((1 << (STORE_BITS-1)) - 1))
        begin
            w_sat = {1'b0, {(STORE_BITS-1){1'b1}}};
            w_hit = 1'b1;
        end
        else if (w_full < -(STORE_BITS+3)'(1 << (STORE_BITS-1)))
        begin
            w_sat = {1'b1, {(STORE_BITS-1){1'b0}}};
            w_hit = 1'b1;
        end
        else
        begin
            w_sat = w_full[STORE_BITS-1:0];
        end
    end

    always_comb
    begin
        sum_out   = {prod_reg[PROD_BITS-1], prod_reg} + SUM_BITS'(8192);
        shift_out = sum_out >>> 14;
        y_hit     = 1'b0;
        if (shift_out > SUM_BITS'((1 << (SAMPLE_BITS-1)) - 1))
        begin
            y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            y_hit = 1'b1;
        end
        else if (shift_out < -SUM_BITS'(1 << (SAMPLE_BITS-1)))
        begin
            y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            y_hit = 1'b1;
        end
        else
        begin
            y_sat = shift_out[SAMPLE_BITS-1:0];
        end
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || echo.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:  state_next = S_ADD;
            S_ADD:   state_next = S_MUL2;
            S_MUL2:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_reg      <= FEEDBACK_GAIN_RESET;
            norm_reg      <= NORM_GAIN_RESET;
            spacing_reg   <= ECHO_SPACING_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (paddr[3:2])
                    REG_FEEDBACK_GAIN: gain_reg    <= pwdata[CFG_BITS-1:0];
                    REG_NORM_GAIN:     norm_reg    <= pwdata[CFG_BITS-1:0];
                    REG_ECHO_SPACING:  spacing_reg <= pwdata[CFG_BITS-1:0];
                    default:           ;
                endcase
            end
            if (accept)
            begin
                fill_reg <= (fill_eff == '1) ? fill_eff : fill_eff + 1'b1;
            end
            if (state_reg == S_ADD)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (echo.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg       <= audio.sample_in;
            gate_reg    <= (fill_eff >= delay);
            rd_data_reg <= echo_mem[rd_addr];
        end
        if (state_reg == S_MUL1 || state_reg == S_MUL2)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == S_ADD)
        begin
            echo_mem[wp_reg] <= w_sat;
            w_reg            <= w_sat;
            hit_reg          <= w_hit;
        end
        if (out_load)
        begin
            out_sample_reg  <= y_sat;
            out_clipped_reg <= hit_reg || y_hit;
        end
    end

    `NCE_ASSERT_NEXT(a_accept_starts, audio.valid && audio.ready, state_reg == S_MUL1, "accepted sample did not start the sequencer")
    `NCE_ASSERT_NEXT(a_fill_nonzero, audio.valid && audio.ready, fill_reg != '0, "fill count zero after a stored sample")
    `NCE_ASSERT_NEXT(a_wp_step, state_reg == S_ADD, wp_reg == $past(wp_reg) + 1'b1, "write pointer did not advance by one")
    `NCE_ASSERT(a_out_from_done, $rose(echo.valid) |-> $past(state_reg) == S_DONE, "result appeared outside the final step")

endmodule
